>>> rtl/xxh_pkg.sv
package xxh_pkg;

    typedef logic [63:0] word_t;

    localparam word_t PRIME1 = 64'd11400714785074694791;
    localparam word_t PRIME2 = 64'd14029467366897019727;
    localparam word_t PRIME3 = 64'd1609587929392839161;
    localparam word_t PRIME4 = 64'd9650029242287828579;
    localparam word_t PRIME5 = 64'd2870177450012600261;

    // Lane start offsets, modulo 2^64
    localparam word_t PRIME12 = PRIME1 + PRIME2;
    localparam word_t NEG_PRIME1 = ~PRIME1 + 64'd1;

    // Rotate left by a constant amount in 1..63
    function automatic word_t rotl(input word_t v, input int unsigned n);
        word_t res;
        res = (v << n) | (v >> (64 - n));
        return res;
    endfunction

endpackage

>>> rtl/xxh_mul.sv
module xxh_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] result
);

    logic [1:0]  step_reg, step_next;
    logic        done_reg, done_next;
    logic [63:0] a_reg, b_reg, res_reg, res_next;
    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;

    // One 32x32 multiplier: low product, then the two cross terms into the upper half
    always_comb
    begin
        case (step_reg)
            2'd1:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
            2'd2:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            default:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
        endcase
        prod = {32'd0, mul_x} * {32'd0, mul_y};
    end

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start)
        begin
            step_next = 2'd1;
        end
        else
        begin
            case (step_reg)
                2'd1:
                begin
                    res_next  = prod;
                    step_next = 2'd2;
                end
                2'd2:
                begin
                    res_next  = {res_reg[63:32] + prod[31:0], res_reg[31:0]};
                    step_next = 2'd3;
                end
                2'd3:
                begin
                    res_next  = {res_reg[63:32] + prod[31:0], res_reg[31:0]};
                    step_next = 2'd0;
                    done_next = 1'b1;
                end
                default:
                begin
                    step_next = 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
        end
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

>>> rtl/xxh64_stream_hash.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_valid / cfg_ready  seed_value[63:0]
// in        in         in_valid / in_ready    data_bytes[63:0], byte_count[3:0], end_of_message
// out       out        out_valid / out_ready  digest[63:0]
//
// A beat that does not complete a stripe passes through the accept and byte-insert states.
// Every multiply runs on one shared 32x32 unit, so a full stripe adds 8 multiplies;
// finalization adds the lane sum and one lane merge per lane (both when 32 or more
// bytes were sent), then one pass per 8-byte tail word, per 4-byte word and per tail
// byte, and last the avalanche and the digest load.
// Reset clears the lanes to the zero-seed start values; the stripe buffer is not cleared.
// The digest sits in an output register, so a stalled out channel blocks input beats
// only once the next digest waits to be loaded, not the beats before that.
module xxh64_stream_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] seed_value,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_bytes,
    input  logic [3:0]  byte_count,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_INS   = 5'd1;
    localparam logic [4:0] ST_ABS_A = 5'd2;
    localparam logic [4:0] ST_ABS_B = 5'd3;
    localparam logic [4:0] ST_FIN   = 5'd4;
    localparam logic [4:0] ST_SUM   = 5'd5;
    localparam logic [4:0] ST_MRG_A = 5'd6;
    localparam logic [4:0] ST_MRG_B = 5'd7;
    localparam logic [4:0] ST_MRG_C = 5'd8;
    localparam logic [4:0] ST_LEN   = 5'd9;
    localparam logic [4:0] ST_TAIL  = 5'd10;
    localparam logic [4:0] ST_T8_A  = 5'd11;
    localparam logic [4:0] ST_T8_B  = 5'd12;
    localparam logic [4:0] ST_T8_C  = 5'd13;
    localparam logic [4:0] ST_T4_A  = 5'd14;
    localparam logic [4:0] ST_T4_B  = 5'd15;
    localparam logic [4:0] ST_T1_A  = 5'd16;
    localparam logic [4:0] ST_T1_B  = 5'd17;
    localparam logic [4:0] ST_AV_A  = 5'd18;
    localparam logic [4:0] ST_AV_B  = 5'd19;
    localparam logic [4:0] ST_DRAIN = 5'd20;

    logic [4:0]       state_reg, state_next;
    logic [63:0]      seed_reg, seed_next;
    logic [3:0][63:0] acc_reg, acc_next;
    logic [255:0]     buf_reg, buf_next;
    logic [4:0]       fill_reg, fill_next;
    logic [63:0]      len_reg, len_next;
    logic [63:0]      data_reg, data_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic             eom_reg, eom_next;
    logic [63:0]      h_reg, h_next;
    logic [1:0]       k_reg, k_next;
    logic [4:0]       left_reg, left_next;
    logic             ov_reg, ov_next;
    logic [63:0]      dig_reg, dig_next;

    logic             mul_start;
    logic [63:0]      mul_a, mul_b;
    logic             mul_done;
    logic [63:0]      mul_r;

    xxh_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .result (mul_r)
    );

    always_comb
    begin
        logic [5:0]  room;
        logic [3:0]  take;
        logic [5:0]  fill_end;
        logic [5:0]  off;
        logic [3:0]  cnt_sat;
        logic [63:0] seed_use;
        logic [63:0] hx;
        logic        restart;

        state_next = state_reg;
        seed_next  = seed_reg;
        acc_next   = acc_reg;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        data_next  = data_reg;
        cnt_next   = cnt_reg;
        eom_next   = eom_reg;
        h_next     = h_reg;
        k_next     = k_reg;
        left_next  = left_reg;
        ov_next    = ov_reg;
        dig_next   = dig_reg;
        mul_start  = 1'b0;
        mul_a      = 64'd0;
        mul_b      = 64'd0;
        restart    = 1'b0;
        off        = 6'd0;
        seed_use   = seed_reg;
        cnt_sat    = (byte_count > 4'd8) ? 4'd8 : byte_count;
        room       = 6'd32 - {1'b0, fill_reg};
        take       = ({2'd0, cnt_reg} < room) ? cnt_reg : room[3:0];
        fill_end   = {1'b0, fill_reg} + {2'd0, take};
        hx         = h_reg ^ mul_r;

        // Drop the output beat once taken
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    seed_next = seed_value;
                    seed_use  = seed_value;
                    restart   = 1'b1;
                end
                else if (in_valid)
                begin
                    data_next  = data_bytes;
                    cnt_next   = cnt_sat;
                    eom_next   = end_of_message;
                    len_next   = len_reg + {60'd0, cnt_sat};
                    state_next = ST_INS;
                end
            end
            ST_INS:
            begin
                // Place as many bytes as fit before the stripe end
                for (int j = 0; j < 32; j++)
                begin
                    off = 6'(j) - {1'b0, fill_reg};
                    if ((6'(j) >= {1'b0, fill_reg}) && (6'(j) < fill_end))
                    begin
                        buf_next[8*j +: 8] = data_reg[{off[2:0], 3'b000} +: 8];
                    end
                end
                data_next = data_reg >> {take, 3'b000};
                cnt_next  = cnt_reg - take;
                if (fill_end == 6'd32)
                begin
                    fill_next  = 5'd0;
                    k_next     = 2'd0;
                    mul_start  = 1'b1;
                    mul_a      = buf_next[63:0];
                    mul_b      = xxh_pkg::PRIME2;
                    state_next = ST_ABS_A;
                end
                else
                begin
                    fill_next = fill_end[4:0];
                    if (cnt_reg == take)
                    begin
                        state_next = eom_reg ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_ABS_A:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = xxh_pkg::rotl(acc_reg[0] + mul_r, 31);
                    mul_b      = xxh_pkg::PRIME1;
                    buf_next   = buf_reg >> 64;
                    state_next = ST_ABS_B;
                end
            end
            ST_ABS_B:
            begin
                if (mul_done)
                begin
                    // Rotate the lanes so the next one sits in slot 0
                    acc_next = {mul_r, acc_reg[3], acc_reg[2], acc_reg[1]};
                    if (k_reg == 2'd3)
                    begin
                        k_next     = 2'd0;
                        state_next = ST_INS;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        mul_start  = 1'b1;
                        mul_a      = buf_reg[63:0];
                        mul_b      = xxh_pkg::PRIME2;
                        state_next = ST_ABS_A;
                    end
                end
            end
            ST_FIN:
            begin
                k_next = 2'd0;
                if (|len_reg[63:5])
                begin
                    h_next     = 64'd0;
                    state_next = ST_SUM;
                end
                else
                begin
                    h_next     = seed_reg + xxh_pkg::PRIME5;
                    state_next = ST_LEN;
                end
            end
            ST_SUM:
            begin
                case (k_reg)
                    2'd0:    h_next = h_reg + xxh_pkg::rotl(acc_reg[0], 1);
                    2'd1:    h_next = h_reg + xxh_pkg::rotl(acc_reg[0], 7);
                    2'd2:    h_next = h_reg + xxh_pkg::rotl(acc_reg[0], 12);
                    default: h_next = h_reg + xxh_pkg::rotl(acc_reg[0], 18);
                endcase
                acc_next = {acc_reg[0], acc_reg[3], acc_reg[2], acc_reg[1]};
                if (k_reg == 2'd3)
                begin
                    k_next     = 2'd0;
                    mul_start  = 1'b1;
                    mul_a      = acc_reg[1];
                    mul_b      = xxh_pkg::PRIME2;
                    state_next = ST_MRG_A;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_MRG_A:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = xxh_pkg::rotl(mul_r, 31);
                    mul_b      = xxh_pkg::PRIME1;
                    state_next = ST_MRG_B;
                end
            end
            ST_MRG_B:
            begin
                if (mul_done)
                begin
                    h_next     = hx;
                    mul_start  = 1'b1;
                    mul_a      = hx;
                    mul_b      = xxh_pkg::PRIME1;
                    state_next = ST_MRG_C;
                end
            end
            ST_MRG_C:
            begin
                if (mul_done)
                begin
                    h_next   = mul_r + xxh_pkg::PRIME4;
                    acc_next = {acc_reg[0], acc_reg[3], acc_reg[2], acc_reg[1]};
                    if (k_reg == 2'd3)
                    begin
                        k_next     = 2'd0;
                        state_next = ST_LEN;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        mul_start  = 1'b1;
                        mul_a      = acc_reg[1];
                        mul_b      = xxh_pkg::PRIME2;
                        state_next = ST_MRG_A;
                    end
                end
            end
            ST_LEN:
            begin
                h_next     = h_reg + len_reg;
                left_next  = fill_reg;
                state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                // Consume the tail from the bottom of the buffer
                mul_start = 1'b1;
                if (left_reg >= 5'd8)
                begin
                    mul_a      = buf_reg[63:0];
                    mul_b      = xxh_pkg::PRIME2;
                    state_next = ST_T8_A;
                end
                else if (left_reg >= 5'd4)
                begin
                    mul_a      = {32'd0, buf_reg[31:0]};
                    mul_b      = xxh_pkg::PRIME1;
                    state_next = ST_T4_A;
                end
                else if (left_reg != 5'd0)
                begin
                    mul_a      = {56'd0, buf_reg[7:0]};
                    mul_b      = xxh_pkg::PRIME5;
                    state_next = ST_T1_A;
                end
                else
                begin
                    mul_a      = h_reg ^ (h_reg >> 33);
                    mul_b      = xxh_pkg::PRIME2;
                    state_next = ST_AV_A;
                end
            end
            ST_T8_A:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = xxh_pkg::rotl(mul_r, 31);
                    mul_b      = xxh_pkg::PRIME1;
                    state_next = ST_T8_B;
                end
            end
            ST_T8_B:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = xxh_pkg::rotl(hx, 27);
                    mul_b      = xxh_pkg::PRIME1;
                    state_next = ST_T8_C;
                end
            end
            ST_T8_C:
            begin
                if (mul_done)
                begin
                    h_next     = mul_r + xxh_pkg::PRIME4;
                    buf_next   = buf_reg >> 64;
                    left_next  = left_reg - 5'd8;
                    state_next = ST_TAIL;
                end
            end
            ST_T4_A:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = xxh_pkg::rotl(hx, 23);
                    mul_b      = xxh_pkg::PRIME2;
                    state_next = ST_T4_B;
                end
            end
            ST_T4_B:
            begin
                if (mul_done)
                begin
                    h_next     = mul_r + xxh_pkg::PRIME3;
                    buf_next   = buf_reg >> 32;
                    left_next  = left_reg - 5'd4;
                    state_next = ST_TAIL;
                end
            end
            ST_T1_A:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = xxh_pkg::rotl(hx, 11);
                    mul_b      = xxh_pkg::PRIME1;
                    state_next = ST_T1_B;
                end
            end
            ST_T1_B:
            begin
                if (mul_done)
                begin
                    h_next     = mul_r;
                    buf_next   = buf_reg >> 8;
                    left_next  = left_reg - 5'd1;
                    state_next = ST_TAIL;
                end
            end
            ST_AV_A:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_r ^ (mul_r >> 29);
                    mul_b      = xxh_pkg::PRIME3;
                    state_next = ST_AV_B;
                end
            end
            ST_AV_B:
            begin
                if (mul_done)
                begin
                    h_next     = mul_r ^ (mul_r >> 32);
                    restart    = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // Hold the digest until the output register is free
                if (!ov_reg || out_ready)
                begin
                    dig_next   = h_reg;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (restart)
        begin
            acc_next[0] = seed_use + xxh_pkg::PRIME12;
            acc_next[1] = seed_use + xxh_pkg::PRIME2;
            acc_next[2] = seed_use;
            acc_next[3] = seed_use + xxh_pkg::NEG_PRIME1;
            fill_next   = 5'd0;
            len_next    = 64'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            seed_reg   <= 64'd0;
            acc_reg[0] <= xxh_pkg::PRIME12;
            acc_reg[1] <= xxh_pkg::PRIME2;
            acc_reg[2] <= 64'd0;
            acc_reg[3] <= xxh_pkg::NEG_PRIME1;
            fill_reg   <= 5'd0;
            len_reg    <= 64'd0;
            k_reg      <= 2'd0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            seed_reg  <= seed_next;
            acc_reg   <= acc_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg  <= buf_next;
        data_reg <= data_next;
        cnt_reg  <= cnt_next;
        eom_reg  <= eom_next;
        h_reg    <= h_next;
        left_reg <= left_next;
        dig_reg  <= dig_next;
    end

    // Seed writes take priority over data beats while idle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = ov_reg;
    assign digest    = dig_reg;

endmodule

>>> rtl/xxh_checker.sv
module xxh_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        in_valid,
    input logic        in_ready,
    input logic        end_of_message,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] digest
);

    // A stalled digest beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digest))
        else $error("digest changed while stalled");

    // An accepted beat keeps the input closed for at least the next cycle
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened right after a beat");

    // A beat without end mark never raises a digest next cycle
    a_no_early_digest: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !end_of_message |=> !$rose(out_valid))
        else $error("digest raised after a non-final beat");

    // A new digest only appears while the block is working
    a_digest_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("digest raised while idle");

    // A seed write closes the data input in the same cycle
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !in_ready)
        else $error("data input open during a seed write");

endmodule

bind xxh64_stream_hash xxh_checker u_xxh_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] seed_value;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        end_of_message;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest;

    xxh64_stream_hash i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .seed_value     (seed_value),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_bytes     (data_bytes),
        .byte_count     (byte_count),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest         (digest)
    );

    // 8 ns period: 4 high, 4 low
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hash model state, kept in step with accepted beats
    xxh_pkg::word_t hm_seed;
    xxh_pkg::word_t hm_lane [4];
    logic [7:0]     hm_stripe [32];
    int unsigned    hm_fill;
    xxh_pkg::word_t hm_len;

    xxh_pkg::word_t digest_queue [$];
    int             fail_count = 0;
    int             send_idle_pct;
    int             recv_stall_pct;
    longint         cycle_count = 0;

    function automatic xxh_pkg::word_t rot_l(xxh_pkg::word_t v, int unsigned n);
        return (v << n) | (v >> (64 - n));
    endfunction

    function automatic xxh_pkg::word_t lane_mix(xxh_pkg::word_t acc, xxh_pkg::word_t lane);
        xxh_pkg::word_t a;
        a = acc + lane * xxh_pkg::PRIME2;
        a = rot_l(a, 31);
        return a * xxh_pkg::PRIME1;
    endfunction

    function automatic xxh_pkg::word_t stripe_word(int unsigned pos, int unsigned n);
        xxh_pkg::word_t v;
        v = '0;
        for (int i = 0; i < n; i++)
            v |= xxh_pkg::word_t'(hm_stripe[pos + i]) << (8 * i);
        return v;
    endfunction

    task automatic restart_hash();
        hm_lane[0] = hm_seed + xxh_pkg::PRIME1 + xxh_pkg::PRIME2;
        hm_lane[1] = hm_seed + xxh_pkg::PRIME2;
        hm_lane[2] = hm_seed;
        hm_lane[3] = hm_seed - xxh_pkg::PRIME1;
        hm_fill    = 0;
        hm_len     = '0;
    endtask

    function automatic xxh_pkg::word_t finish_hash();
        xxh_pkg::word_t h;
        int unsigned    pos;
        int unsigned    left;
        pos  = 0;
        left = hm_fill;
        if (hm_len >= 32)
        begin
            h = rot_l(hm_lane[0], 1) + rot_l(hm_lane[1], 7)
              + rot_l(hm_lane[2], 12) + rot_l(hm_lane[3], 18);
            for (int k = 0; k < 4; k++)
            begin
                h ^= lane_mix('0, hm_lane[k]);
                h = h * xxh_pkg::PRIME1 + xxh_pkg::PRIME4;
            end
        end
        else
            h = hm_seed + xxh_pkg::PRIME5;
        h += hm_len;
        while (left >= 8)
        begin
            h ^= lane_mix('0, stripe_word(pos, 8));
            h = rot_l(h, 27) * xxh_pkg::PRIME1 + xxh_pkg::PRIME4;
            pos += 8;
            left -= 8;
        end
        if (left >= 4)
        begin
            h ^= stripe_word(pos, 4) * xxh_pkg::PRIME1;
            h = rot_l(h, 23) * xxh_pkg::PRIME2 + xxh_pkg::PRIME3;
            pos += 4;
            left -= 4;
        end
        while (left > 0)
        begin
            h ^= xxh_pkg::word_t'(hm_stripe[pos]) * xxh_pkg::PRIME5;
            h = rot_l(h, 11) * xxh_pkg::PRIME1;
            pos++;
            left--;
        end
        h ^= h >> 33;
        h *= xxh_pkg::PRIME2;
        h ^= h >> 29;
        h *= xxh_pkg::PRIME3;
        h ^= h >> 32;
        return h;
    endfunction

    // Fold one accepted beat into the model; queue a digest on the end mark
    task automatic absorb_beat(xxh_pkg::word_t data, logic [3:0] cnt, logic last);
        int unsigned n;
        n = (cnt > 8) ? 8 : cnt;
        hm_len += n;
        for (int i = 0; i < n; i++)
        begin
            hm_stripe[hm_fill] = data[8*i +: 8];
            hm_fill++;
            if (hm_fill == 32)
            begin
                for (int k = 0; k < 4; k++)
                    hm_lane[k] = lane_mix(hm_lane[k], stripe_word(8 * k, 8));
                hm_fill = 0;
            end
        end
        if (last)
        begin
            digest_queue.push_back(finish_hash());
            restart_hash();
        end
    endtask

    // Send one beat, idling first at the current rate
    task automatic send_beat(xxh_pkg::word_t data, logic [3:0] cnt, logic last);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        in_valid       <= 1'b1;
        data_bytes     <= data;
        byte_count     <= cnt;
        end_of_message <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_beat(data, cnt, last);
        in_valid <= 1'b0;
        // Wait for the next clock edge: the block is never ready right after a beat
        @(posedge clk);
    endtask

    // Wait for every queued digest, then let finalization drain
    task automatic drain_digests();
        while (digest_queue.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_seed(xxh_pkg::word_t s);
        drain_digests();
        cfg_valid  <= 1'b1;
        seed_value <= s;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        hm_seed = s;
        restart_hash();
    endtask

    // Receiver: stall at the current rate, check each digest beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("digest: unexpected beat, actual %h", digest);
                    fail_count++;
                end
                else
                begin
                    if (digest !== digest_queue[0])
                    begin
                        $error("digest: expected %h actual %h", digest_queue[0], digest);
                        fail_count++;
                    end
                    void'(digest_queue.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 3000000)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_message(int unsigned nbytes);
        int unsigned rem;
        int unsigned n;
        rem = nbytes;
        do
        begin
            n = (rem > 8) ? 8 : rem;
            if (n != 0 && $urandom_range(3) == 0)
                n = $urandom_range(n, 1);
            rem -= n;
            send_beat({$urandom, $urandom}, 4'(n), rem == 0);
        end
        while (rem != 0);
    endtask

    task automatic test_directed();
        send_beat('0, 4'd0, 1'b1);                       // empty message
        send_beat('1, 4'd8, 1'b0);
        send_beat('0, 4'd0, 1'b0);                       // zero bytes, no end: no effect
        send_beat('1, 4'd15, 1'b1);                      // count above eight saturates
        for (int i = 0; i < 4; i++)
            send_beat('1, 4'd8, 1'b0);                   // exactly one stripe
        send_beat('0, 4'd0, 1'b1);
        for (int i = 1; i <= 7; i++)
            send_beat({$urandom, $urandom}, 4'(i), 1'b0);
        send_beat('0, 4'd12, 1'b1);
        send_message(37);
        send_message(63);
    endtask

    task automatic test_seed_extremes();
        write_seed('1);
        send_message(0);
        send_message(45);
        send_beat({$urandom, $urandom}, 4'd5, 1'b0);
        write_seed(64'h8000_0000_0000_0001);             // pending bytes discarded
        send_message(11);
        write_seed('0);
        send_message(32);
    endtask

    task automatic test_random(int n_msgs);
        for (int m = 0; m < n_msgs; m++)
        begin
            if ($urandom_range(9) == 0)
                send_message($urandom_range(200, 64));
            else
                send_message($urandom_range(40));
        end
    endtask

    task automatic test_pause_until_empty();
        send_message(50);
        while (digest_queue.size() != 0)
            @(posedge clk);
        send_message(3);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        seed_value     = '0;
        in_valid       = 1'b0;
        data_bytes     = '0;
        byte_count     = '0;
        end_of_message = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hm_seed        = '0;
        restart_hash();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_seed_extremes();
        test_pause_until_empty();

        // Random traffic over the send-idle and receive-stall phases, new seed each phase
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = (p == 1) ? 50 : (p == 3) ? 25 : 0;
            recv_stall_pct = (p == 2) ? 50 : (p == 3) ? 25 : 0;
            write_seed({$urandom, $urandom});
            test_random(56);
        end

        drain_digests();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
